// File: rtl/lek_pkg.sv
// Shared constants and types for the line edit key engine.
`timescale 1ns / 1ps
package lek_pkg;
    // Event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_REDRAW = 3'd1;
    localparam logic [2:0] EV_BELL   = 3'd2;
    localparam logic [2:0] EV_ACCEPT = 3'd3;
    localparam logic [2:0] EV_EOF    = 3'd4;
    localparam logic [2:0] EV_CANCEL = 3'd5;
    localparam logic [2:0] EV_CLEAR  = 3'd6;

    // Key codes
    localparam logic [7:0] K_DEL   = 8'h7F;
    localparam logic [7:0] K_BS    = 8'h08;
    localparam logic [7:0] K_CTL_D = 8'h04;
    localparam logic [7:0] K_CTL_C = 8'h03;
    localparam logic [7:0] K_CTL_L = 8'h0C;
    localparam logic [7:0] K_CTL_A = 8'h01;
    localparam logic [7:0] K_CTL_E = 8'h05;
    localparam logic [7:0] K_CTL_K = 8'h0B;
    localparam logic [7:0] K_CTL_U = 8'h15;
    localparam logic [7:0] K_ESC   = 8'h1B;
    localparam logic [7:0] K_LF    = 8'h0A;
    localparam logic [7:0] K_CR    = 8'h0D;
    localparam logic [7:0] K_TILDE = 8'h7E;
    localparam logic [7:0] K_UNDER = 8'h5F;

    // Escape phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;
    localparam logic [1:0] PH_DIG  = 2'd3;

    // Memory access request from the sequencer
    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic [5:0] rd_addr;
    } t_mem_req;

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == K_UNDER;
    endfunction
endpackage

// File: rtl/lek_store.sv
// Line byte memory: one write port, one registered read port.
`timescale 1ns / 1ps
module lek_store import lek_pkg::*; #(
    parameter int LINE_MAX = 64
) (
    input  logic           i_clk,
    input  t_mem_req       i_req,
    output logic [7:0]     o_rd_data
);
    localparam int AW = $clog2(LINE_MAX);
    logic [7:0] r_mem [LINE_MAX];

    // Write and read the line bytes
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        o_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
    end
endmodule

// File: rtl/line_edit_key_engine_core.sv
// Top level: key decode, edit sequencer and result strobe around the line memory.
`timescale 1ns / 1ps
// One key byte is taken when i_start is high and o_busy low. Cursor moves and
// mode keys go from decode straight to the result word; edits that shift
// bytes, scan words or emit the line walk the line memory byte by byte
// through its single read port. Each result word is shown for one cycle
// with o_valid; the receiver cannot stall, and o_last_of_run marks the final
// word of a key. Enter on a line of n bytes gives n words, one per memory
// read; on an empty line it gives a single word.
module line_edit_key_engine_core import lek_pkg::*; #(
    parameter int LINE_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_key_byte,
    output logic       o_busy,
    output logic       o_valid,
    output logic [2:0] o_event_kind,
    output logic       o_byte_valid,
    output logic [7:0] o_line_byte,
    output logic       o_last_of_run,
    output logic [6:0] o_line_length,
    output logic [6:0] o_cursor_pos,
    output logic       o_overwrite_on
);
    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SCANF = 4'd2;
    localparam logic [3:0] S_SCANB = 4'd3;
    localparam logic [3:0] S_CUT   = 4'd4;
    localparam logic [3:0] S_INS   = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    // Scan purposes
    localparam logic [1:0] P_MOVE = 2'd0;
    localparam logic [1:0] P_KILL = 2'd1;

    logic [3:0] r_state, n_state;
    logic [7:0] r_key;
    logic [6:0] r_len, n_len, r_cur, n_cur;
    logic       r_ovr, n_ovr;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_dig, n_dig;
    logic [6:0] r_i, n_i;       // scan / copy index
    logic       r_inw, n_inw;   // scan reached word part
    logic [1:0] r_purp, n_purp;
    logic [6:0] r_s, n_s, r_e, n_e;  // span to cut
    logic [7:0] r_hold, n_hold;      // byte carried during insert shift
    logic       r_rdv, n_rdv;        // read data in flight
    logic [2:0] r_ev, n_ev;

    t_mem_req   mreq;
    logic [7:0] rd_data;

    lek_store #(.LINE_MAX(LINE_MAX)) u_store (
        .i_clk     (i_clk),
        .i_req     (mreq),
        .o_rd_data (rd_data)
    );

    logic [6:0] lmax;
    assign lmax = 7'(LINE_MAX);

    // Output word fields
    logic       ov_valid, ov_bv, ov_last;
    logic [2:0] ov_ev;
    logic [7:0] ov_byte;
    logic [6:0] ov_len, ov_cur;
    logic       ov_ovr;

    // Sequencer next state
    always_comb begin
        n_state = r_state; n_len = r_len; n_cur = r_cur; n_ovr = r_ovr;
        n_phase = r_phase; n_dig = r_dig; n_i = r_i; n_inw = r_inw;
        n_purp = r_purp; n_s = r_s; n_e = r_e; n_hold = r_hold;
        n_rdv = 1'b0; n_ev = r_ev;
        mreq = '0;
        ov_valid = 1'b0; ov_bv = 1'b0; ov_last = 1'b1; ov_ev = r_ev;
        ov_byte = 8'd0; ov_len = r_len; ov_cur = r_cur; ov_ovr = r_ovr;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_ev = EV_NONE;
                n_phase = PH_IDLE;
                n_state = S_DONE;
                if (r_phase == PH_ESC) begin
                    if (r_key == 8'h5B) begin
                        n_phase = PH_CSI;
                    end else if (r_key == 8'h64 || r_key == 8'h44) begin
                        if (r_cur < r_len) begin
                            n_ev = EV_REDRAW; n_purp = P_KILL; n_s = r_cur;
                            n_i = r_cur; n_inw = 1'b0; n_state = S_SCANF;
                        end
                    end else if (r_key == 8'h66 || r_key == 8'h46) begin
                        n_ev = EV_REDRAW; n_purp = P_MOVE;
                        n_i = r_cur; n_inw = 1'b0; n_state = S_SCANF;
                    end else if (r_key == 8'h62 || r_key == 8'h42) begin
                        n_ev = EV_REDRAW; n_purp = P_MOVE;
                        n_i = r_cur; n_inw = 1'b0; n_state = S_SCANB;
                    end else if (r_key == K_BS || r_key == K_DEL) begin
                        if (r_cur != 7'd0) begin
                            n_ev = EV_REDRAW; n_purp = P_KILL; n_e = r_cur;
                            n_i = r_cur; n_inw = 1'b0; n_state = S_SCANB;
                        end
                    end
                end else if (r_phase == PH_CSI) begin
                    if (r_key == 8'h43) begin
                        if (r_cur < r_len) begin n_cur = r_cur + 7'd1; n_ev = EV_REDRAW; end
                    end else if (r_key == 8'h44) begin
                        if (r_cur != 7'd0) begin n_cur = r_cur - 7'd1; n_ev = EV_REDRAW; end
                    end else if (r_key == 8'h48) begin
                        n_cur = 7'd0; n_ev = EV_REDRAW;
                    end else if (r_key == 8'h46) begin
                        n_cur = r_len; n_ev = EV_REDRAW;
                    end else if (r_key >= 8'h30 && r_key <= 8'h39) begin
                        n_dig = 4'(r_key - 8'h30);
                        n_phase = PH_DIG;
                    end
                end else if (r_phase == PH_DIG) begin
                    if (r_key == K_TILDE) begin
                        if (r_dig == 4'd2) begin
                            n_ovr = ~r_ovr;
                        end else if (r_dig == 4'd1) begin
                            n_cur = 7'd0; n_ev = EV_REDRAW;
                        end else if (r_dig == 4'd4) begin
                            n_cur = r_len; n_ev = EV_REDRAW;
                        end
                    end
                end else if (r_key == K_LF || r_key == K_CR) begin
                    n_ev = EV_ACCEPT;
                    n_i = 7'd0;
                    mreq.rd_addr = 6'd0;
                    n_rdv = 1'b1;
                    n_state = S_EMIT;
                end else if (r_key == K_DEL || r_key == K_BS) begin
                    if (r_cur != 7'd0) begin
                        n_ev = EV_REDRAW; n_s = r_cur - 7'd1; n_e = r_cur;
                        n_i = r_cur - 7'd1; n_state = S_CUT;
                    end
                end else if (r_key == K_CTL_D) begin
                    if (r_len == 7'd0) begin
                        n_ev = EV_EOF;
                    end else if (r_cur < r_len) begin
                        n_ev = EV_REDRAW; n_s = r_cur; n_e = r_cur + 7'd1;
                        n_i = r_cur; n_state = S_CUT;
                    end
                end else if (r_key == K_CTL_C) begin
                    n_len = 7'd0; n_cur = 7'd0; n_ev = EV_CANCEL;
                end else if (r_key == K_CTL_L) begin
                    n_ev = EV_CLEAR;
                end else if (r_key == K_CTL_A) begin
                    n_cur = 7'd0; n_ev = EV_REDRAW;
                end else if (r_key == K_CTL_E) begin
                    n_cur = r_len; n_ev = EV_REDRAW;
                end else if (r_key == K_CTL_K) begin
                    if (r_cur < r_len) begin n_len = r_cur; n_ev = EV_REDRAW; end
                end else if (r_key == K_CTL_U) begin
                    if (r_cur != 7'd0) begin
                        n_ev = EV_REDRAW; n_s = 7'd0; n_e = r_cur;
                        n_i = 7'd0; n_state = S_CUT;
                    end
                end else if (r_key == K_ESC) begin
                    n_phase = PH_ESC;
                end else if (r_key >= 8'h20 && r_key < 8'h7F) begin
                    if (r_ovr && r_cur < r_len) begin
                        mreq.wr_en = 1'b1; mreq.wr_addr = r_cur[5:0];
                        mreq.wr_data = r_key;
                        n_cur = r_cur + 7'd1; n_ev = EV_REDRAW;
                    end else if (r_len >= lmax) begin
                        n_ev = EV_BELL;
                    end else begin
                        // shift tail right one byte, carrying the displaced byte
                        n_ev = EV_REDRAW; n_hold = r_key; n_i = r_cur;
                        mreq.rd_addr = r_cur[5:0]; n_rdv = 1'b1;
                        n_state = S_INS;
                    end
                end
            end
            S_SCANF: begin
                // scan forward: skip non-word then word bytes
                if (!r_rdv) begin
                    if (r_i >= r_len) begin
                        if (r_purp == P_MOVE) begin
                            n_cur = r_i; n_state = S_DONE;
                        end else begin
                            n_e = r_i; n_i = r_s; n_state = S_CUT;
                        end
                    end else begin
                        mreq.rd_addr = r_i[5:0]; n_rdv = 1'b1;
                    end
                end else if (r_inw && !word_char(rd_data)) begin
                    if (r_purp == P_MOVE) begin
                        n_cur = r_i; n_state = S_DONE;
                    end else begin
                        n_e = r_i; n_i = r_s; n_state = S_CUT;
                    end
                end else begin
                    if (word_char(rd_data)) n_inw = 1'b1;
                    n_i = r_i + 7'd1;
                end
            end
            S_SCANB: begin
                // scan backward over byte r_i-1
                if (!r_rdv) begin
                    if (r_i == 7'd0) begin
                        if (r_purp == P_MOVE) begin
                            n_cur = r_i; n_state = S_DONE;
                        end else begin
                            n_s = r_i; n_state = S_CUT;
                        end
                    end else begin
                        mreq.rd_addr = 6'(r_i - 7'd1); n_rdv = 1'b1;
                    end
                end else if (r_inw && !word_char(rd_data)) begin
                    if (r_purp == P_MOVE) begin
                        n_cur = r_i; n_state = S_DONE;
                    end else begin
                        n_s = r_i; n_state = S_CUT;
                    end
                end else begin
                    if (word_char(rd_data)) n_inw = 1'b1;
                    n_i = r_i - 7'd1;
                end
            end
            S_CUT: begin
                // copy byte at i+(e-s) down to i; r_i runs from s
                if (!r_rdv) begin
                    if (r_i + (r_e - r_s) >= r_len) begin
                        n_len = r_len - (r_e - r_s);
                        if (r_cur > r_e) n_cur = r_cur - (r_e - r_s);
                        else if (r_cur > r_s) n_cur = r_s;
                        n_state = S_DONE;
                    end else begin
                        mreq.rd_addr = 6'(r_i + (r_e - r_s)); n_rdv = 1'b1;
                    end
                end else begin
                    mreq.wr_en = 1'b1; mreq.wr_addr = r_i[5:0];
                    mreq.wr_data = rd_data;
                    n_i = r_i + 7'd1;
                end
            end
            S_INS: begin
                // write carried byte at i, carry old byte onward
                if (r_rdv) begin
                    mreq.wr_en = 1'b1; mreq.wr_addr = r_i[5:0];
                    mreq.wr_data = r_hold;
                    n_hold = rd_data;
                    n_i = r_i + 7'd1;
                    if (r_i >= r_len) begin
                        n_len = r_len + 7'd1; n_cur = r_cur + 7'd1;
                        n_state = S_DONE;
                    end
                end else begin
                    mreq.rd_addr = r_i[5:0]; n_rdv = 1'b1;
                end
            end
            S_EMIT: begin
                // stream line bytes, one word per read
                if (r_len == 7'd0) begin
                    ov_valid = 1'b1; ov_ev = EV_ACCEPT; ov_len = 7'd0; ov_cur = 7'd0;
                    n_cur = 7'd0; n_state = S_IDLE;
                end else begin
                    ov_valid = 1'b1; ov_ev = EV_ACCEPT; ov_bv = 1'b1;
                    ov_byte = rd_data; ov_cur = 7'd0;
                    ov_last = (r_i + 7'd1 == r_len);
                    mreq.rd_addr = 6'(r_i + 7'd1); n_rdv = 1'b1;
                    n_i = r_i + 7'd1;
                    if (r_i + 7'd1 == r_len) begin
                        n_len = 7'd0; n_cur = 7'd0; n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                ov_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_len <= '0; r_cur <= '0; r_ovr <= 1'b0;
            r_phase <= PH_IDLE; r_dig <= '0; r_rdv <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_len <= n_len; r_cur <= n_cur; r_ovr <= n_ovr;
            r_phase <= n_phase; r_dig <= n_dig; r_rdv <= n_rdv;
            o_valid <= ov_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) r_key <= i_key_byte;
        r_i <= n_i; r_inw <= n_inw; r_purp <= n_purp; r_s <= n_s; r_e <= n_e;
        r_hold <= n_hold; r_ev <= n_ev;
        o_event_kind <= ov_ev; o_byte_valid <= ov_bv; o_line_byte <= ov_byte;
        o_last_of_run <= ov_last; o_line_length <= ov_len; o_cursor_pos <= ov_cur;
        o_overwrite_on <= ov_ovr;
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: test/line_edit_key_engine_core_tb.sv
// Self-checking testbench for the line edit key engine core.
`timescale 1ns / 1ps
module line_edit_key_engine_core_tb;
    import lek_pkg::*;

    localparam int LMAX = 64;

    typedef struct packed {
        logic [2:0] event_kind;
        logic       byte_valid;
        logic [7:0] line_byte;
        logic       last_of_run;
        logic [6:0] line_length;
        logic [6:0] cursor_pos;
        logic       overwrite_on;
    } t_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic [7:0] i_key_byte;
    logic       o_busy;
    logic       o_valid;
    logic [2:0] o_event_kind;
    logic       o_byte_valid;
    logic [7:0] o_line_byte;
    logic       o_last_of_run;
    logic [6:0] o_line_length;
    logic [6:0] o_cursor_pos;
    logic       o_overwrite_on;

    line_edit_key_engine_core #(.LINE_MAX(LMAX)) dut (.*);

    // Editor state mirror
    logic [7:0] line_mirror [LMAX];
    int         len_m;
    int         cur_m;
    bit         ovr_m;
    logic [1:0] phase_m;
    int         digit_m;

    t_word      pending_words [$];
    int         fail_count;
    bit         calm;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_word_byte(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == K_UNDER;
    endfunction

    // Remove bytes [s, e) and pull the cursor along
    function automatic void cut_bytes(int s, int e);
        if (s >= e || e > len_m) return;
        for (int k = s; k < len_m - (e - s); k++) line_mirror[k] = line_mirror[k + e - s];
        len_m -= e - s;
        if (cur_m > e) cur_m -= e - s;
        else if (cur_m > s) cur_m = s;
    endfunction

    function automatic int word_end(int i);
        while (i < len_m && !is_word_byte(line_mirror[i])) i++;
        while (i < len_m && is_word_byte(line_mirror[i])) i++;
        return i;
    endfunction

    function automatic int word_start(int i);
        while (i > 0 && !is_word_byte(line_mirror[i - 1])) i--;
        while (i > 0 && is_word_byte(line_mirror[i - 1])) i--;
        return i;
    endfunction

    function automatic void push_word(logic [2:0] ev, bit bv, logic [7:0] b, bit last,
                                      int len, int cur);
        t_word w;
        w.event_kind = ev; w.byte_valid = bv; w.line_byte = b; w.last_of_run = last;
        w.line_length = 7'(len); w.cursor_pos = 7'(cur); w.overwrite_on = ovr_m;
        pending_words.push_back(w);
    endfunction

    // Apply one key to the mirror and queue the words it causes
    function automatic void edit_line(logic [7:0] c);
        logic [2:0] ev;
        logic [1:0] ph;
        int n;
        ev = EV_NONE;
        ph = phase_m;
        phase_m = PH_IDLE;
        if (ph == PH_ESC) begin
            if (c == "[") phase_m = PH_CSI;
            else if (c == "d" || c == "D") begin
                if (cur_m < len_m) begin cut_bytes(cur_m, word_end(cur_m)); ev = EV_REDRAW; end
            end else if (c == "f" || c == "F") begin
                cur_m = word_end(cur_m); ev = EV_REDRAW;
            end else if (c == "b" || c == "B") begin
                cur_m = word_start(cur_m); ev = EV_REDRAW;
            end else if (c == K_BS || c == K_DEL) begin
                if (cur_m > 0) begin cut_bytes(word_start(cur_m), cur_m); ev = EV_REDRAW; end
            end
        end else if (ph == PH_CSI) begin
            if (c == "C") begin
                if (cur_m < len_m) begin cur_m++; ev = EV_REDRAW; end
            end else if (c == "D") begin
                if (cur_m > 0) begin cur_m--; ev = EV_REDRAW; end
            end else if (c == "H") begin
                cur_m = 0; ev = EV_REDRAW;
            end else if (c == "F") begin
                cur_m = len_m; ev = EV_REDRAW;
            end else if (c >= "0" && c <= "9") begin
                digit_m = c - "0"; phase_m = PH_DIG;
            end
        end else if (ph == PH_DIG) begin
            if (c == K_TILDE) begin
                if (digit_m == 2) ovr_m = !ovr_m;
                else if (digit_m == 1) begin cur_m = 0; ev = EV_REDRAW; end
                else if (digit_m == 4) begin cur_m = len_m; ev = EV_REDRAW; end
            end
        end else if (c == K_LF || c == K_CR) begin
            n = len_m;
            len_m = 0;
            cur_m = 0;
            if (n == 0) push_word(EV_ACCEPT, 0, 8'h00, 1, 0, 0);
            for (int k = 0; k < n; k++)
                push_word(EV_ACCEPT, 1, line_mirror[k], k + 1 == n, n, 0);
            return;
        end else if (c == K_DEL || c == K_BS) begin
            if (cur_m > 0) begin cut_bytes(cur_m - 1, cur_m); ev = EV_REDRAW; end
        end else if (c == K_CTL_D) begin
            if (len_m == 0) ev = EV_EOF;
            else if (cur_m < len_m) begin cut_bytes(cur_m, cur_m + 1); ev = EV_REDRAW; end
        end else if (c == K_CTL_C) begin
            len_m = 0; cur_m = 0; ev = EV_CANCEL;
        end else if (c == K_CTL_L) ev = EV_CLEAR;
        else if (c == K_CTL_A) begin cur_m = 0; ev = EV_REDRAW; end
        else if (c == K_CTL_E) begin cur_m = len_m; ev = EV_REDRAW; end
        else if (c == K_CTL_K) begin
            if (cur_m < len_m) begin cut_bytes(cur_m, len_m); ev = EV_REDRAW; end
        end else if (c == K_CTL_U) begin
            if (cur_m > 0) begin cut_bytes(0, cur_m); ev = EV_REDRAW; end
        end else if (c == K_ESC) phase_m = PH_ESC;
        else if (c >= 8'h20 && c < 8'h7F) begin
            if (ovr_m && cur_m < len_m) begin
                line_mirror[cur_m] = c; cur_m++; ev = EV_REDRAW;
            end else if (len_m >= LMAX) ev = EV_BELL;
            else begin
                for (int k = len_m; k > cur_m; k--) line_mirror[k] = line_mirror[k - 1];
                line_mirror[cur_m] = c; len_m++; cur_m++; ev = EV_REDRAW;
            end
        end
        push_word(ev, 0, 8'h00, 1, len_m, cur_m);
    endfunction

    // Send one key byte, with a random gap before it unless calm is set; hold start until taken
    task automatic send_key(logic [7:0] c);
        if (!calm) begin
            while ($urandom_range(99) < 37) begin
                i_start <= 1'b0;
                i_key_byte <= 8'($urandom);
                @(posedge i_clk);
            end
        end
        i_start <= 1'b1;
        i_key_byte <= c;
        do @(posedge i_clk); while (o_busy);
        edit_line(c);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_key(s[k]);
    endtask

    // Drop start and wait until every expected word has come
    task automatic drain_words();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // Compare each strobed word with the oldest expectation
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && o_valid) begin
            if (pending_words.size() == 0) begin
                $error("unexpected word: event_kind %0d", o_event_kind);
                fail_count++;
            end else begin
                w = pending_words.pop_front();
                if (o_event_kind !== w.event_kind) begin
                    $error("event_kind exp %0d got %0d", w.event_kind, o_event_kind);
                    fail_count++;
                end
                if (o_byte_valid !== w.byte_valid) begin
                    $error("byte_valid exp %0d got %0d", w.byte_valid, o_byte_valid);
                    fail_count++;
                end
                if (o_line_byte !== w.line_byte) begin
                    $error("line_byte exp %h got %h", w.line_byte, o_line_byte);
                    fail_count++;
                end
                if (o_last_of_run !== w.last_of_run) begin
                    $error("last_of_run exp %0d got %0d", w.last_of_run, o_last_of_run);
                    fail_count++;
                end
                if (o_line_length !== w.line_length) begin
                    $error("line_length exp %0d got %0d", w.line_length, o_line_length);
                    fail_count++;
                end
                if (o_cursor_pos !== w.cursor_pos) begin
                    $error("cursor_pos exp %0d got %0d", w.cursor_pos, o_cursor_pos);
                    fail_count++;
                end
                if (o_overwrite_on !== w.overwrite_on) begin
                    $error("overwrite_on exp %0d got %0d", w.overwrite_on, o_overwrite_on);
                    fail_count++;
                end
            end
        end
    end

    // Edge cases on an empty line, then a full line with bell and overwrite
    task automatic test_directed();
        send_key(K_LF);
        send_key(K_CTL_D);
        send_key(K_BS);
        send_key(K_CTL_U);
        send_key(8'hFF);
        send_key(8'h80);
        send_key(K_CTL_L);
        send_text("a_9 Z~");
        send_key(K_ESC); send_key("b");
        send_key(K_ESC); send_key(K_DEL);
        send_key(K_ESC); send_text("[D");
        send_key(K_CTL_D);
        send_key(K_ESC); send_text("[2~");
        send_key(8'h20);
        send_key(K_ESC); send_text("[2~");
        send_key(K_CR);
        for (int k = 0; k < LMAX; k++) send_key(8'($urandom_range(8'h7E, 8'h20)));
        send_key("x");
        send_key(K_CTL_A);
        send_key(K_ESC); send_text("[2~");
        send_key("Q");
        send_key(K_ESC); send_text("[2~");
        send_key(K_LF);
    endtask

    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 8'($urandom_range(8'h7E, 8'h20));
        if (r < 55) return 8'($urandom);
        if (r < 62) return (r & 1) ? "_" : " ";
        case ($urandom_range(13))
            0: return K_DEL;
            1: return K_BS;
            2: return K_CTL_D;
            3: return K_CTL_A;
            4: return K_CTL_E;
            5: return K_CTL_K;
            6: return K_CTL_U;
            7: return K_CTL_L;
            8: return ($urandom_range(9) == 0) ? K_CTL_C : K_CTL_A;
            9: return ($urandom_range(2) == 0) ? K_CR : K_LF;
            default: return K_ESC;
        endcase
    endfunction

    // Random keys; escape starts mostly run into well-formed sequences
    task automatic test_random(int count);
        logic [7:0] c;
        string tails [14] = '{"b", "B", "f", "F", "d", "D", "[C", "[D", "[H",
                              "[F", "[1~", "[4~", "[2~", "[A"};
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3 && n < count / 2);
            c = pick_key();
            send_key(c);
            if (c == K_ESC && $urandom_range(9) < 8) begin
                if ($urandom_range(9) == 0) send_key(K_DEL);
                else if ($urandom_range(9) == 0) begin
                    send_key("[");
                    send_key(8'($urandom_range(8'h39, 8'h30)));
                    send_key(8'($urandom));
                end
                else send_text(tails[$urandom_range(13)]);
            end
        end
        calm = 1'b0;
    endtask

    // Hold off until every expected word has come, then send Enter
    task automatic test_hold_off();
        send_text("hold off");
        drain_words();
        send_key(K_CR);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_key_byte = 8'h00;
        len_m = 0; cur_m = 0; ovr_m = 0; phase_m = PH_IDLE; digit_m = 0;
        fail_count = 0;
        calm = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_hold_off();
        test_random(230);
        send_key(K_LF);
        drain_words();
        repeat (2 * LMAX + 20) @(posedge i_clk);
        if (fail_count == 0 && pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
